// ===== rtl/core/vra_pkg.sv =====
`default_nettype none
package vra_pkg;

  localparam int unsigned MaxRangesDefault = 64;
  localparam int unsigned PageShiftDefault = 12;

  localparam logic [31:0] ResetHeapStart  = 32'h1000_0000;
  localparam logic [31:0] ResetHeapLength = 32'h3000_0000;

  localparam int unsigned CountW = 29;
  localparam int unsigned WantW  = 30;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_DROPPED  = 2'd2
  } status_t;

  typedef enum logic {
    REG_HEAP_START  = 1'b0,
    REG_HEAP_LENGTH = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic        op;
    logic [28:0] byte_count;
    logic [31:0] range_start;
  } req_t;

  typedef struct packed {
    logic [31:0] address;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_FIX,
    S_SHIFT_DN,
    S_PLACE,
    S_SHIFT_UP,
    S_INS,
    S_BUMP
  } state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/va_range_allocator_top.sv =====
// channel   | signals                          | transfer
// ----------+----------------------------------+------------------------------------
// request   | start, busy, req                 | rising edge with start & !busy
// result    | done, rsp                        | every cycle done is high, no stall
// config    | wr_en, wr_index, wr_data         | rising edge with wr_en high
//
// an alloc walks the free table one entry a cycle, then either shrinks the entry,
// closes the gap one entry a cycle, or bump-allocates; the walk and the close-up
// together pass over the table once
// a free walks up to its insertion point, then merges with a neighbour or opens a gap
// one entry a cycle, or is dropped when the table is full; the single read port sets this pace
// zero-size requests are answered in the cycle after acceptance; the table needs no clearing after reset
// rst is synchronous, clears the free count and sets the bump pointer to the
// reset heap start; config writes never touch the table or bump pointer
// the result strobe lasts one cycle and the receiver cannot stall it
`default_nettype none
module va_range_allocator_top
  import vra_pkg::*;
#(
  parameter int unsigned MAX_RANGES = MaxRangesDefault,
  parameter int unsigned PAGE_SHIFT = PageShiftDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req,
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [31:0] wr_data,
  output logic             done,
  output rsp_t             rsp
);

  localparam int unsigned IW = $clog2(MAX_RANGES);
  localparam logic [WantW-1:0] PageMask = WantW'((64'd1 << PAGE_SHIFT) - 64'd1);

  // heap bounds; the user must write them only while idle, the block does not enforce it
  logic [31:0] heap_start, heap_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_start  <= ResetHeapStart;
      heap_length <= ResetHeapLength;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_HEAP_START:  heap_start  <= wr_data;
        REG_HEAP_LENGTH: heap_length <= wr_data;
        default: ;
      endcase
    end
  end

  // round the byte count up to whole pages
  logic [WantW-1:0] want;
  assign want = ({1'b0, req.byte_count} + PageMask) & ~PageMask;

  logic          accept;
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  ent_t          mem_wdata, mem_rdata;

  assign accept = start & ~busy;

  vra_ctrl #(
    .MAX_RANGES(MAX_RANGES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (req.op),
    .want       (want),
    .base       (req.range_start),
    .heap_start (heap_start),
    .heap_length(heap_length),
    .busy       (busy),
    .done       (done),
    .rsp        (rsp),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // sorted free-range table
  vra_mem #(
    .DEPTH(MAX_RANGES)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/core/vra_mem.sv =====
`default_nettype none
module vra_mem
  import vra_pkg::*;
#(
  parameter int unsigned DEPTH = MaxRangesDefault
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire ent_t                     wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output ent_t                          rdata
);

  ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/vra_ctrl.sv =====
`default_nettype none
module vra_ctrl
  import vra_pkg::*;
#(
  parameter int unsigned MAX_RANGES = MaxRangesDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic                          op,
  input  wire logic [WantW-1:0]              want,
  input  wire logic [31:0]                   base,
  input  wire logic [31:0]                   heap_start,
  input  wire logic [31:0]                   heap_length,
  output logic                               busy,
  output logic                               done,
  output rsp_t                               rsp,
  output logic                               mem_we,
  output logic [$clog2(MAX_RANGES)-1:0]      mem_waddr,
  output ent_t                               mem_wdata,
  output logic [$clog2(MAX_RANGES)-1:0]      mem_raddr,
  input  wire ent_t                          mem_rdata
);

  localparam int unsigned IW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);

  state_t           state, state_next;
  logic [CW-1:0]    idx, idx_next;
  logic [CW-1:0]    pos, pos_next;
  logic [CW-1:0]    count, count_next;
  logic [31:0]      bump, bump_next;
  logic             op_r, op_r_next;
  logic [WantW-1:0] want_r, want_r_next;
  logic [31:0]      base_r, base_r_next;
  logic [31:0]      res_addr, res_addr_next;
  ent_t             hold, hold_next;
  logic             done_next;
  rsp_t             rsp_next;

  logic [31:0] want32;
  logic        last;
  logic [32:0] end_i, end_req, end_hold, limit, bump_end;

  assign want32   = {{(32 - WantW){1'b0}}, want_r};
  assign last     = (idx + CW'(1)) == count;
  assign end_i    = {1'b0, mem_rdata.start} + {1'b0, mem_rdata.length};
  assign end_req  = {1'b0, base_r} + {1'b0, want32};
  assign end_hold = {1'b0, hold.start} + {1'b0, hold.length};
  assign bump_end = {1'b0, bump} + {1'b0, want32};
  assign busy     = state != S_IDLE;

  always_comb begin
    limit = {1'b0, heap_start} + {1'b0, heap_length};
    if (limit > 33'h1_0000_0000) begin
      limit = 33'h1_0000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      bump  <= ResetHeapStart;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      bump  <= bump_next;
      done  <= done_next;
    end
    idx      <= idx_next;
    pos      <= pos_next;
    op_r     <= op_r_next;
    want_r   <= want_r_next;
    base_r   <= base_r_next;
    res_addr <= res_addr_next;
    hold     <= hold_next;
    rsp      <= rsp_next;
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    pos_next      = pos;
    count_next    = count;
    bump_next     = bump;
    op_r_next     = op_r;
    want_r_next   = want_r;
    base_r_next   = base_r;
    res_addr_next = res_addr;
    hold_next     = hold;
    done_next     = 1'b0;
    rsp_next      = rsp;
    mem_we        = 1'b0;
    mem_waddr     = idx[IW-1:0];
    mem_wdata     = mem_rdata;
    mem_raddr     = IW'(idx + CW'(1));

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_r_next     = op;
          want_r_next   = want;
          base_r_next   = base;
          res_addr_next = '0;
          idx_next      = '0;
          mem_raddr     = '0;
          if (want == '0) begin
            done_next = 1'b1;
            rsp_next  = '{address: 32'd0,
                          status: (op == OP_ALLOC) ? ST_NO_SPACE : ST_OK};
          end else if (count == '0) begin
            pos_next   = '0;
            state_next = (op == OP_ALLOC) ? S_BUMP : S_PLACE;
          end else begin
            state_next = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (op_r == OP_ALLOC) begin
          if (mem_rdata.length >= want32) begin
            res_addr_next = mem_rdata.start;
            if (mem_rdata.length > want32) begin
              mem_we     = 1'b1;
              mem_wdata  = '{start: mem_rdata.start + want32,
                             length: mem_rdata.length - want32};
              done_next  = 1'b1;
              rsp_next   = '{address: mem_rdata.start, status: ST_OK};
              state_next = S_IDLE;
            end else if (last) begin
              // exact fit on the last entry, nothing to close up
              count_next = count - CW'(1);
              done_next  = 1'b1;
              rsp_next   = '{address: mem_rdata.start, status: ST_OK};
              state_next = S_IDLE;
            end else begin
              // read of idx+1 already issued, close the gap from there
              idx_next   = idx + CW'(1);
              state_next = S_SHIFT_DN;
            end
          end else if (last) begin
            state_next = S_BUMP;
          end else begin
            idx_next = idx + CW'(1);
          end
        end else begin
          if (end_i == {1'b0, base_r}) begin
            hold_next = '{start: mem_rdata.start,
                          length: sat_add(mem_rdata.length, want32)};
            if (last) begin
              mem_we     = 1'b1;
              mem_wdata  = hold_next;
              done_next  = 1'b1;
              rsp_next   = '{address: 32'd0, status: ST_OK};
              state_next = S_IDLE;
            end else begin
              state_next = S_FIX;
            end
          end else if (mem_rdata.start > base_r) begin
            pos_next = idx;
            if ({1'b0, mem_rdata.start} == end_req) begin
              // returned range abuts the front of this one
              mem_we     = 1'b1;
              mem_wdata  = '{start: base_r,
                             length: sat_add(mem_rdata.length, want32)};
              done_next  = 1'b1;
              rsp_next   = '{address: 32'd0, status: ST_OK};
              state_next = S_IDLE;
            end else begin
              state_next = S_PLACE;
            end
          end else if (last) begin
            pos_next   = count;
            state_next = S_PLACE;
          end else begin
            idx_next = idx + CW'(1);
          end
        end
      end

      S_FIX: begin
        // mem_rdata is the entry after the merged one
        mem_we = 1'b1;
        if (end_hold == {1'b0, mem_rdata.start}) begin
          mem_wdata = '{start: hold.start,
                        length: sat_add(hold.length, mem_rdata.length)};
          if ((idx + CW'(2)) == count) begin
            count_next = count - CW'(1);
            done_next  = 1'b1;
            rsp_next   = '{address: 32'd0, status: ST_OK};
            state_next = S_IDLE;
          end else begin
            mem_raddr  = IW'(idx + CW'(2));
            idx_next   = idx + CW'(2);
            state_next = S_SHIFT_DN;
          end
        end else begin
          mem_wdata  = hold;
          done_next  = 1'b1;
          rsp_next   = '{address: 32'd0, status: ST_OK};
          state_next = S_IDLE;
        end
      end

      S_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(idx - CW'(1));
        mem_wdata = mem_rdata;
        if (last) begin
          count_next = count - CW'(1);
          done_next  = 1'b1;
          rsp_next   = '{address: res_addr, status: ST_OK};
          state_next = S_IDLE;
        end else begin
          idx_next = idx + CW'(1);
        end
      end

      S_PLACE: begin
        if (count == CW'(MAX_RANGES)) begin
          done_next  = 1'b1;
          rsp_next   = '{address: 32'd0, status: ST_DROPPED};
          state_next = S_IDLE;
        end else if (pos == count) begin
          state_next = S_INS;
        end else begin
          mem_raddr  = IW'(count - CW'(1));
          idx_next   = count - CW'(1);
          state_next = S_SHIFT_UP;
        end
      end

      S_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(idx + CW'(1));
        mem_wdata = mem_rdata;
        if (idx == pos) begin
          state_next = S_INS;
        end else begin
          mem_raddr = IW'(idx - CW'(1));
          idx_next  = idx - CW'(1);
        end
      end

      S_INS: begin
        mem_we     = 1'b1;
        mem_waddr  = pos[IW-1:0];
        mem_wdata  = '{start: base_r, length: want32};
        count_next = count + CW'(1);
        done_next  = 1'b1;
        rsp_next   = '{address: 32'd0, status: ST_OK};
        state_next = S_IDLE;
      end

      S_BUMP: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (bump_end > limit) begin
          rsp_next = '{address: 32'd0, status: ST_NO_SPACE};
        end else begin
          rsp_next  = '{address: bump, status: ST_OK};
          bump_next = bump_end[31:0];
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RANGES))
    else $error("free count above table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count == $past(count) || count == $past(count) + CW'(1) ||
    count + CW'(1) == $past(count))
    else $error("free count moved by more than one");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while still working");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state != S_IDLE)
    else $error("table write while idle");

  a_bump_alloc: assert property (@(posedge clk) disable iff (rst)
    bump != $past(bump) |-> $past(state) == S_BUMP && op_r == OP_ALLOC)
    else $error("bump pointer moved outside bump step");
`endif

endmodule
`default_nettype wire
